// ----- sv/rc4_stream_cipher_top_assert.svh -----
// Assertion macros shared by the RC4 cipher modules.
// No dependencies; included by rc4_ctrl and rc4_datapath.
`ifndef RC4_STREAM_CIPHER_TOP_ASSERT_SVH
`define RC4_STREAM_CIPHER_TOP_ASSERT_SVH

// Checked property, disabled while reset is asserted.
`define RC4_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checked property that must also hold during reset.
`define RC4_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/rc4_pkg.sv -----
// Shared constants, datapath command codes and control structs for the RC4 cipher.
// No dependencies; used by rc4_ctrl, rc4_datapath and rc4_stream_cipher_top.
package rc4_pkg;

    localparam int SBOX_SIZE         = 256;
    localparam int SBOX_AW           = 8;
    localparam int MAX_KEY_BYTES_DEF = 256;

    localparam logic [SBOX_AW-1:0] SBOX_LAST = SBOX_AW'(SBOX_SIZE - 1);

    typedef enum logic [3:0] {
        DP_NOP,
        DP_INIT,
        DP_KEY_WR,
        DP_KS_RD,
        DP_KS_J,
        DP_KS_W1,
        DP_KS_W2,
        DP_KS_FIN,
        DP_D_ACC,
        DP_D_RDI,
        DP_D_RDJ,
        DP_D_W1,
        DP_D_W2,
        DP_D_RDK,
        DP_D_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic n_last;
    } status_t;

endpackage

// ----- sv/rc4_datapath.sv -----
// RC4 datapath: permutation memory, key store, indices, key count and output register.
// Depends on rc4_pkg and rc4_stream_cipher_top_assert.svh; driven by rc4_ctrl.
`include "rc4_stream_cipher_top_assert.svh"

module rc4_datapath #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rc4_pkg::cmd_t    cmd,
    output rc4_pkg::status_t status,
    input  logic [7:0]       byte_in,
    input  logic             item_last,
    output logic [7:0]       byte_out,
    output logic             out_last
);

    localparam int CW  = $clog2(MAX_KEY_BYTES + 1);
    localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    logic [7:0] sbox_mem [rc4_pkg::SBOX_SIZE];
    logic [7:0] key_mem  [MAX_KEY_BYTES];

    logic [rc4_pkg::SBOX_AW-1:0] n_reg, n_next;
    logic [7:0]     i_reg, i_next;
    logic [7:0]     j_reg, j_next;
    logic [KAW-1:0] kidx_reg, kidx_next;
    logic [CW-1:0]  count_reg, count_next;

    logic [7:0] rdata_reg;
    logic [7:0] key_rdata_reg;
    logic [7:0] si_reg;
    logic [7:0] sj_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic [7:0] byte_out_reg;
    logic       out_last_reg;

    logic [rc4_pkg::SBOX_AW-1:0] mem_addr;
    logic       mem_we;
    logic [7:0] mem_wdata;
    logic [7:0] acc;
    logic [7:0] ks_sum;
    logic [CW-1:0] key_len;
    logic [CW-1:0] kidx_inc;

    assign acc      = j_reg + rdata_reg + key_rdata_reg;
    assign ks_sum   = si_reg + sj_reg;
    assign key_len  = (count_reg == '0) ? CW'(1) : count_reg;
    assign kidx_inc = CW'(kidx_reg) + CW'(1);

    always_comb
    begin
        mem_addr   = n_reg;
        mem_we     = 1'b0;
        mem_wdata  = si_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        kidx_next  = kidx_reg;
        count_next = count_reg;
        unique case (cmd.op)
            rc4_pkg::DP_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = n_reg;
                n_next    = n_reg + 1'b1;
                j_next    = '0;
                kidx_next = '0;
            end
            rc4_pkg::DP_KEY_WR:
            begin
                if (count_reg < CW'(MAX_KEY_BYTES))
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            rc4_pkg::DP_KS_RD:
            begin
                mem_addr = n_reg;
            end
            rc4_pkg::DP_KS_J:
            begin
                mem_addr = acc;
                j_next   = acc;
            end
            rc4_pkg::DP_KS_W1:
            begin
                mem_addr  = j_reg;
                mem_we    = 1'b1;
                mem_wdata = si_reg;
            end
            rc4_pkg::DP_KS_W2:
            begin
                mem_addr  = n_reg;
                mem_we    = 1'b1;
                mem_wdata = sj_reg;
                n_next    = n_reg + 1'b1;
                // key index runs modulo the loaded key length
                kidx_next = (kidx_inc >= key_len) ? '0 : kidx_inc[KAW-1:0];
            end
            rc4_pkg::DP_KS_FIN:
            begin
                i_next     = '0;
                j_next     = '0;
                count_next = '0;
            end
            rc4_pkg::DP_D_ACC:
            begin
                i_next = i_reg + 1'b1;
            end
            rc4_pkg::DP_D_RDI:
            begin
                mem_addr = i_reg;
            end
            rc4_pkg::DP_D_RDJ:
            begin
                mem_addr = j_reg + rdata_reg;
                j_next   = j_reg + rdata_reg;
            end
            rc4_pkg::DP_D_W1:
            begin
                mem_addr  = i_reg;
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
            end
            rc4_pkg::DP_D_W2:
            begin
                mem_addr  = j_reg;
                mem_we    = 1'b1;
                mem_wdata = si_reg;
            end
            rc4_pkg::DP_D_RDK,
            rc4_pkg::DP_D_OUT:
            begin
                mem_addr = ks_sum;
            end
            default:
            begin
                mem_addr = n_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            kidx_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            kidx_reg  <= kidx_next;
            count_reg <= count_next;
        end
    end

    // permutation memory: one port, registered read-before-write
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sbox_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= sbox_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == rc4_pkg::DP_KEY_WR && count_reg < CW'(MAX_KEY_BYTES))
        begin
            key_mem[count_reg[KAW-1:0]] <= byte_in;
        end
        key_rdata_reg <= key_mem[kidx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == rc4_pkg::DP_KS_J || cmd.op == rc4_pkg::DP_D_RDJ)
        begin
            si_reg <= rdata_reg;
        end
        if (cmd.op == rc4_pkg::DP_KS_W1 || cmd.op == rc4_pkg::DP_D_W1)
        begin
            sj_reg <= rdata_reg;
        end
        if (cmd.op == rc4_pkg::DP_D_ACC)
        begin
            byte_reg <= byte_in;
            last_reg <= item_last;
        end
        if (cmd.out_load)
        begin
            byte_out_reg <= byte_reg ^ rdata_reg;
            out_last_reg <= last_reg;
        end
    end

    assign status.n_last = (n_reg == rc4_pkg::SBOX_LAST);
    assign byte_out      = byte_out_reg;
    assign out_last      = out_last_reg;

    `RC4_ASSERT(a_count_max, clk, rst_n, count_reg <= CW'(MAX_KEY_BYTES), "key count overflow")
    `RC4_ASSERT(a_kidx_range, clk, rst_n, (cmd.op == rc4_pkg::DP_KS_RD) |-> (CW'(kidx_reg) < key_len), "key index out of range")
    `RC4_ASSERT(a_fin_clear, clk, rst_n, (cmd.op == rc4_pkg::DP_KS_FIN) |=> (i_reg == '0 && j_reg == '0 && count_reg == '0), "rekey did not clear indices")

endmodule

// ----- sv/rc4_ctrl.sv -----
// RC4 controller: sequences reset fill, key schedule and per-byte keystream steps.
// Depends on rc4_pkg and rc4_stream_cipher_top_assert.svh; commands rc4_datapath.
`include "rc4_stream_cipher_top_assert.svh"

module rc4_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             operation,
    input  logic             item_last,
    output logic             out_valid,
    input  logic             out_ready,
    output rc4_pkg::cmd_t    cmd,
    input  rc4_pkg::status_t status
);

    typedef enum logic [12:0] {
        S_INIT  = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_KS_RD = 13'b0000000000100,
        S_KS_J  = 13'b0000000001000,
        S_KS_W1 = 13'b0000000010000,
        S_KS_W2 = 13'b0000000100000,
        S_KS_FIN= 13'b0000001000000,
        S_D_RDI = 13'b0000010000000,
        S_D_RDJ = 13'b0000100000000,
        S_D_W1  = 13'b0001000000000,
        S_D_W2  = 13'b0010000000000,
        S_D_RDK = 13'b0100000000000,
        S_D_OUT = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   sched_reg, sched_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        sched_next   = sched_reg;
        cmd.op       = rc4_pkg::DP_NOP;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op = rc4_pkg::DP_INIT;
                if (status.n_last)
                begin
                    state_next = sched_reg ? S_KS_RD : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!operation)
                    begin
                        cmd.op = rc4_pkg::DP_KEY_WR;
                        if (item_last)
                        begin
                            sched_next = 1'b1;
                            state_next = S_INIT;
                        end
                    end
                    else
                    begin
                        cmd.op     = rc4_pkg::DP_D_ACC;
                        state_next = S_D_RDI;
                    end
                end
            end
            S_KS_RD:
            begin
                cmd.op     = rc4_pkg::DP_KS_RD;
                state_next = S_KS_J;
            end
            S_KS_J:
            begin
                cmd.op     = rc4_pkg::DP_KS_J;
                state_next = S_KS_W1;
            end
            S_KS_W1:
            begin
                cmd.op     = rc4_pkg::DP_KS_W1;
                state_next = S_KS_W2;
            end
            S_KS_W2:
            begin
                cmd.op     = rc4_pkg::DP_KS_W2;
                state_next = status.n_last ? S_KS_FIN : S_KS_RD;
            end
            S_KS_FIN:
            begin
                cmd.op     = rc4_pkg::DP_KS_FIN;
                sched_next = 1'b0;
                state_next = S_IDLE;
            end
            S_D_RDI:
            begin
                cmd.op     = rc4_pkg::DP_D_RDI;
                state_next = S_D_RDJ;
            end
            S_D_RDJ:
            begin
                cmd.op     = rc4_pkg::DP_D_RDJ;
                state_next = S_D_W1;
            end
            S_D_W1:
            begin
                cmd.op     = rc4_pkg::DP_D_W1;
                state_next = S_D_W2;
            end
            S_D_W2:
            begin
                cmd.op     = rc4_pkg::DP_D_W2;
                state_next = S_D_RDK;
            end
            S_D_RDK:
            begin
                cmd.op     = rc4_pkg::DP_D_RDK;
                state_next = S_D_OUT;
            end
            S_D_OUT:
            begin
                cmd.op = rc4_pkg::DP_D_OUT;
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sched_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sched_reg     <= sched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `RC4_ASSERT(a_no_overwrite, clk, rst_n, (cmd.out_load && out_valid_reg) |-> out_ready, "pending result overwritten")
    `RC4_ASSERT(a_last_key_sched, clk, rst_n, (accept && !operation && item_last) |=> (state_reg == S_INIT && sched_reg), "last key did not start schedule")
    `RC4_ASSERT(a_load_valid, clk, rst_n, cmd.out_load |=> (out_valid_reg && state_reg == S_IDLE), "result load not presented")

endmodule

// ----- sv/rc4_stream_cipher_top.sv -----
// RC4 stream cipher top level. Data byte: accepted in IDLE, then RDI, RDJ, W1, W2, RDK, OUT
// (single-port permutation memory, one access a cycle); OUT loads the result once no earlier
// one is pending, and the next request is taken back in IDLE. Key byte: stored in IDLE; the
// last one adds the schedule: identity fill, then RD, J, W1, W2 per entry, then FIN.
// Reset: async active low; an identity fill of the permutation follows reset, during
// which no request is taken. Depends on rc4_pkg, rc4_ctrl and rc4_datapath.
module rc4_stream_cipher_top #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [7:0] byte_in,
    input  logic       item_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] byte_out,
    output logic       out_last
);

    rc4_pkg::cmd_t    cmd;
    rc4_pkg::status_t status;

    rc4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .item_last (item_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    rc4_datapath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .byte_in   (byte_in),
        .item_last (item_last),
        .byte_out  (byte_out),
        .out_last  (out_last)
    );

endmodule
